### hw/rtl/escaped_length_frame_receiver_core_assert.svh
// Assertion macros for the escaped length frame receiver.
`ifndef ESCAPED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH
`define ESCAPED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define ELFR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("elfr assertion failed: implication");

// Condition that holds at every rising clock edge outside reset.
`define ELFR_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
    else $error("elfr assertion failed: invariant");

`endif

### hw/rtl/elfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// elfr_pkg
// Types and constants of the escaped length frame receiver.
// ---------------------------------------------------------------------------
package elfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Bytes at or above this value are control codes unless escaped.
  localparam logic [BYTE_W-1:0] HIGH_BYTE_LIMIT = 8'd254;

  localparam logic [BYTE_W-1:0] COMMAND_CODE_RST   = 8'd255;
  localparam logic [BYTE_W-1:0] NEW_FRAME_CODE_RST = 8'd1;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST    = 8'd254;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST     = 16'd512;
  localparam logic              LENGTH_BE_RST      = 1'b0;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMAND_CODE      = 3'd0,
    CFG_NEW_FRAME_CODE    = 3'd1,
    CFG_ESCAPE_CODE       = 3'd2,
    CFG_MAX_LENGTH        = 3'd3,
    CFG_LENGTH_BIG_ENDIAN = 3'd4
  } cfg_reg_t;

  // Progress through the two length bytes.
  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_ONE  = 2'd1,
    LEN_DONE = 2'd2
  } len_phase_t;

endpackage
`default_nettype wire

### hw/rtl/escaped_length_frame_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// escaped_length_frame_receiver_core
// Byte-stuffed, length-prefixed frame receiver.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle, unless in_stall is high, and emits the
// payload bytes of each frame with their index and a last flag. A byte moves
// from the input register to the result register, and a payload byte is
// offered on out_valid once it is in the result register; both registers
// hold while out_stall is high and out_valid is shown, and in_stall rises
// only when the input register is full and the result register cannot move.
// Register writes take effect on the next cycle.

`include "escaped_length_frame_receiver_core_assert.svh"

module escaped_length_frame_receiver_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire elfr_pkg::byte_t    in_rx_byte,
  // payload output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output elfr_pkg::byte_t         out_payload_byte,
  output elfr_pkg::len_t          out_byte_index,
  output logic                    out_is_last,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire elfr_pkg::cfg_idx_t cfg_index,
  input  wire elfr_pkg::cfg_data_t cfg_data
);
  import elfr_pkg::*;

  // configuration
  byte_t command_code_r, new_frame_code_r, escape_code_r;
  len_t  max_length_r;
  logic  length_be_r;

  // input register
  logic  s1_vld_r;
  byte_t s1_byte_r;

  // frame state
  logic       receiving_r, receiving_nxt;
  byte_t      prev_byte_r;
  len_phase_t len_phase_r, len_phase_nxt;
  byte_t      first_len_r, first_len_nxt;
  len_t       frame_len_r, frame_len_nxt;
  len_t       count_r, count_nxt;

  // result register
  logic  out_vld_r;
  byte_t out_byte_r;
  len_t  out_idx_r;
  logic  out_last_r;

  logic  advance;
  logic  dropped;
  logic  produced;
  logic  marker;
  len_t  assembled_len;
  len_t  count_inc;

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = s1_vld_r && !advance;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_vld_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_is_last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_code_r   <= COMMAND_CODE_RST;
      new_frame_code_r <= NEW_FRAME_CODE_RST;
      escape_code_r    <= ESCAPE_CODE_RST;
      max_length_r     <= MAX_LENGTH_RST;
      length_be_r      <= LENGTH_BE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COMMAND_CODE:      command_code_r   <= cfg_data[BYTE_W-1:0];
        CFG_NEW_FRAME_CODE:    new_frame_code_r <= cfg_data[BYTE_W-1:0];
        CFG_ESCAPE_CODE:       escape_code_r    <= cfg_data[BYTE_W-1:0];
        CFG_MAX_LENGTH:        max_length_r     <= cfg_data[LEN_W-1:0];
        CFG_LENGTH_BIG_ENDIAN: length_be_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: load on transfer, empty when the byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  assign dropped = (s1_byte_r >= HIGH_BYTE_LIMIT) && (prev_byte_r != escape_code_r);
  assign marker  = (prev_byte_r == command_code_r) && (s1_byte_r == new_frame_code_r);
  assign assembled_len = length_be_r ? {first_len_r, s1_byte_r} : {s1_byte_r, first_len_r};
  assign count_inc = count_r + len_t'(1);

  always_comb begin
    receiving_nxt = receiving_r;
    len_phase_nxt = len_phase_r;
    first_len_nxt = first_len_r;
    frame_len_nxt = frame_len_r;
    count_nxt     = count_r;
    produced      = 1'b0;
    if (receiving_r && !dropped) begin
      case (len_phase_r)
        LEN_NONE: begin
          first_len_nxt = s1_byte_r;
          len_phase_nxt = LEN_ONE;
        end
        LEN_ONE: begin
          len_phase_nxt = LEN_DONE;
          frame_len_nxt = assembled_len;
          if (assembled_len > max_length_r) begin
            receiving_nxt = 1'b0;
          end
        end
        default: begin
          if (count_r < frame_len_r) begin
            count_nxt = count_inc;
            produced  = 1'b1;
          end
        end
      endcase
    end
    // marker check follows data handling and overrides its receiving flag, count and length phase, not produced
    if (marker) begin
      receiving_nxt = 1'b1;
      count_nxt     = '0;
      len_phase_nxt = LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      prev_byte_r <= '0;
      len_phase_r <= LEN_NONE;
      first_len_r <= '0;
      frame_len_r <= '0;
      count_r     <= '0;
    end else if (s1_vld_r && advance) begin
      receiving_r <= receiving_nxt;
      prev_byte_r <= s1_byte_r;
      len_phase_r <= len_phase_nxt;
      first_len_r <= first_len_nxt;
      frame_len_r <= frame_len_nxt;
      count_r     <= count_nxt;
    end
  end

  // result register: reload or drain when the output side moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r && produced;
    end
  end

  // last flag comes from the data count, before a marker can clear it
  always_ff @(posedge clk) begin
    if (advance && s1_vld_r && produced) begin
      out_byte_r <= s1_byte_r;
      out_idx_r  <= count_r;
      out_last_r <= (count_inc == frame_len_r);
    end
  end

  // a shown result matches the frame state it left behind
  `ELFR_ASSERT_IMPL(a_out_idx_tracks_count, clk, rst_n, out_vld_r && (len_phase_r == LEN_DONE), ({1'b0, out_idx_r} + 17'd1) == {1'b0, count_r})
  `ELFR_ASSERT_ALWAYS(a_count_within_len, clk, rst_n, count_r <= frame_len_r)
  `ELFR_ASSERT_IMPL(a_stall_needs_full_stage, clk, rst_n, in_stall, s1_vld_r && out_vld_r)

endmodule
`default_nettype wire
